### rtl/core/mexp_pkg.sv
// Package for the modular exponentiation block: sequencer states and the
// status group that the shared modular multiplier reports. No dependencies.
`timescale 1ns / 1ps

package mexp_pkg;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RED  = 6'b000010,
        S_LOOP = 6'b000100,
        S_MULR = 6'b001000,
        S_SQR  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    // Status of the shared modular multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_status;

endpackage

### rtl/core/mexp_mulmod.sv
// Bit-serial modular multiplier: (a * b) mod m, one multiplier bit per cycle.
// Depends on mexp_pkg for the status struct.
`timescale 1ns / 1ps

module mexp_mulmod #(
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [WIDTH-1:0]         i_a,
    input  logic [WIDTH-1:0]         i_b,
    input  logic [WIDTH-1:0]         i_m,
    output mexp_pkg::t_mul_status    o_status,
    output logic [WIDTH-1:0]         o_product
);
    import mexp_pkg::*;

    localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    // (x + y) mod m for x, y < m without overflow (also right for y = 1, m = 1)
    function automatic logic [WIDTH-1:0] add_mod(
        input logic [WIDTH-1:0] x,
        input logic [WIDTH-1:0] y,
        input logic [WIDTH-1:0] m
    );
        logic [WIDTH-1:0] gap;
        begin
            gap = m - y;
            if (x >= gap) begin
                add_mod = x - gap;
            end else begin
                add_mod = x + y;
            end
        end
    endfunction

    logic [WIDTH-1:0] r_acc, r_a, r_b, r_m;
    logic [CW-1:0]    r_cnt;
    logic             r_busy, r_done;
    logic [WIDTH-1:0] w_dbl, w_step;

    // Double, then add the multiplicand when the current multiplier bit is set
    always_comb begin
        w_dbl  = add_mod(r_acc, r_acc, r_m);
        w_step = r_b[WIDTH-1] ? add_mod(w_dbl, r_a, r_m) : w_dbl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_acc <= w_step;
                r_b   <= r_b << 1;
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_acc  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
                r_m    <= i_m;
                r_cnt  <= CW'(WIDTH - 1);
                r_busy <= 1'b1;
            end
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_product     = r_acc;

endmodule

### rtl/core/modular_exponentiation_top.sv
// Modular exponentiation by right-to-left square-and-multiply.
// Depends on mexp_pkg and mexp_mulmod (shared bit-serial modular multiplier).
// A zero modulus goes straight to the result. Else the base is reduced, then per exponent
// bit up to the highest set one the result is multiplied by the base when the bit is set
// and the base is squared; then the result goes to the output register. One item at a time.
// Reset (synchronous, active low) clears the sequencer and the output valid.
`timescale 1ns / 1ps

module modular_exponentiation_top #(
    parameter int WIDTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Input transaction
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata, low to high: base_value, exponent, modulus (WIDTH bits each)
    input  logic [((3*WIDTH+7)/8)*8-1:0]           s_axis_tdata,
    // Result transaction
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // tdata, low to high: power_result (WIDTH bits), zero padding
    output logic [((WIDTH+7)/8)*8-1:0]             m_axis_tdata,
    // tuser: zero_modulus_error
    output logic                                   m_axis_tuser
);
    import mexp_pkg::*;

    localparam int OUT_W = ((WIDTH + 7) / 8) * 8;

    t_state           r_state;
    logic [WIDTH-1:0] r_b;       // running base (power of two of the input base)
    logic [WIDTH-1:0] r_e;       // remaining exponent bits
    logic [WIDTH-1:0] r_m;       // modulus
    logic [WIDTH-1:0] r_res;     // running result
    logic             r_err;
    logic             r_mul_start;
    logic [WIDTH-1:0] r_mul_a, r_mul_b;
    logic             r_out_valid;
    logic [WIDTH-1:0] r_out_data;
    logic             r_out_err;

    t_mul_status      w_mul_status;
    logic [WIDTH-1:0] w_product;
    logic             w_in_acc;
    logic             w_out_free;
    logic [WIDTH-1:0] w_in_base, w_in_exp, w_in_mod;

    assign w_in_base = s_axis_tdata[WIDTH-1:0];
    assign w_in_exp  = s_axis_tdata[2*WIDTH-1:WIDTH];
    assign w_in_mod  = s_axis_tdata[3*WIDTH-1:2*WIDTH];

    // Take a new item only when the sequencer is idle
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    // Output register can take a result when empty or draining this cycle
    assign w_out_free    = !r_out_valid || m_axis_tready;

    mexp_mulmod #(
        .WIDTH (WIDTH)
    ) u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_mul_start),
        .i_a       (r_mul_a),
        .i_b       (r_mul_b),
        .i_m       (r_m),
        .o_status  (w_mul_status),
        .o_product (w_product)
    );

    // Sequencer: flag a zero modulus, else reduce base, then per exponent bit multiply (if set) and square
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mul_start <= 1'b0;
        end else begin
            r_mul_start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_e <= w_in_exp;
                        r_m <= w_in_mod;
                        if (w_in_mod == '0) begin
                            // Zero modulus: flag the error, return 0
                            r_res   <= '0;
                            r_err   <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            // 1 mod m; base mod m computed as (1 * base) mod m
                            r_res       <= (w_in_mod == WIDTH'(1)) ? '0 : WIDTH'(1);
                            r_err       <= 1'b0;
                            r_mul_a     <= WIDTH'(1);
                            r_mul_b     <= w_in_base;
                            r_mul_start <= 1'b1;
                            r_state     <= S_RED;
                        end
                    end
                end
                S_RED: begin
                    if (w_mul_status.done) begin
                        r_b     <= w_product;
                        r_state <= S_LOOP;
                    end
                end
                S_LOOP: begin
                    if (r_e == '0) begin
                        r_state <= S_DONE;
                    end else if (r_e[0]) begin
                        r_mul_a     <= r_res;
                        r_mul_b     <= r_b;
                        r_mul_start <= 1'b1;
                        r_state     <= S_MULR;
                    end else begin
                        r_mul_a     <= r_b;
                        r_mul_b     <= r_b;
                        r_mul_start <= 1'b1;
                        r_state     <= S_SQR;
                    end
                end
                S_MULR: begin
                    if (w_mul_status.done) begin
                        // Update result, then square the base
                        r_res       <= w_product;
                        r_mul_a     <= r_b;
                        r_mul_b     <= r_b;
                        r_mul_start <= 1'b1;
                        r_state     <= S_SQR;
                    end
                end
                S_SQR: begin
                    if (w_mul_status.done) begin
                        r_b     <= w_product;
                        r_e     <= r_e >> 1;
                        r_state <= S_LOOP;
                    end
                end
                S_DONE: begin
                    // Hold until the output register has room
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register: load on completion, drop once the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
                r_out_data  <= r_res;
                r_out_err   <= r_err;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_out_data);
    assign m_axis_tuser  = r_out_err;

    // The multiplier never runs while the sequencer takes a new item
    a_idle_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_mul_status.busy)
        else $error("multiplier busy while sequencer idle");

    // A finished product only arrives where the sequencer waits for one
    a_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_status.done |-> (r_state == S_RED || r_state == S_MULR || r_state == S_SQR))
        else $error("multiplier result in unexpected state");

    // An error result always carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (r_out_data == '0))
        else $error("error result with nonzero value");

    // Each start lands while the multiplier is free and makes it busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mul_start |-> (!w_mul_status.busy ##1 w_mul_status.busy))
        else $error("multiplier start lost");

endmodule

### sim/modular_exponentiation_top_tb.sv
// Self-checking testbench for modular_exponentiation_top: drives base, exponent and
// modulus transactions with random idling and checks every result against a local
// square-and-multiply model. Depends only on the RTL of the block.
`timescale 1ns / 1ps

module modular_exponentiation_top_tb;

    localparam int WIDTH       = 32;
    localparam int IN_W        = ((3*WIDTH+7)/8)*8;
    localparam int OUT_W       = ((WIDTH+7)/8)*8;
    // Extra wait at the end of the run, after every result has come back.
    localparam int TAIL_CYCLES = 2400;
    localparam int CYCLE_LIMIT = 4000000;

    localparam logic [WIDTH-1:0] ALL_ONES = '1;

    typedef struct packed {
        logic [WIDTH-1:0] power;
        logic             zero_mod;
    } power_exp_t;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            s_axis_tvalid = 1'b0;
    logic            s_axis_tready;
    // tdata, low to high: base_value, exponent, modulus
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic            m_axis_tvalid;
    logic            m_axis_tready = 1'b0;
    // tdata, low to high: power_result, zero padding
    logic [OUT_W-1:0] m_axis_tdata;
    // tuser: zero_modulus_error
    logic            m_axis_tuser;

    power_exp_t expected_powers[$];
    int         error_count = 0;
    int         cycle_count = 0;
    int         stall_left = 0;
    bit         idle_on = 1'b1;
    bit         idle_mix = 1'b1;

    modular_exponentiation_top #(
        .WIDTH(WIDTH)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // Right-to-left square-and-multiply; products fit in twice the width.
    function automatic power_exp_t predict_power(input logic [WIDTH-1:0] base_v,
                                                 input logic [WIDTH-1:0] exp_v,
                                                 input logic [WIDTH-1:0] mod_v);
        logic [2*WIDTH-1:0] acc;
        logic [2*WIDTH-1:0] sq;
        logic [2*WIDTH-1:0] m;
        power_exp_t         res;
        if (mod_v == '0) begin
            res.power    = '0;
            res.zero_mod = 1'b1;
            return res;
        end
        m   = mod_v;
        acc = 1 % m;
        sq  = base_v % m;
        for (int i = 0; i < WIDTH; i++) begin
            if (exp_v[i])
                acc = (acc * sq) % m;
            sq = (sq * sq) % m;
        end
        res.power    = acc[WIDTH-1:0];
        res.zero_mod = 1'b0;
        return res;
    endfunction

    // Hold one transaction until accepted, with an optional idle burst first.
    task automatic send_item(input logic [WIDTH-1:0] base_v,
                             input logic [WIDTH-1:0] exp_v,
                             input logic [WIDTH-1:0] mod_v);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {mod_v, exp_v, base_v};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_powers.push_back(predict_power(base_v, exp_v, mod_v));
    endtask

    // Drop valid and hold until every expected result has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_powers.size() != 0);
    endtask

    // Exponent of random bit length, so most items stay short.
    function automatic logic [WIDTH-1:0] random_exponent();
        int len;
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        len = $urandom_range(0, WIDTH);
        if (len == 0)
            return '0;
        return ($urandom | (1 << (WIDTH-1))) >> (WIDTH - len);
    endfunction

    function automatic logic [WIDTH-1:0] random_modulus();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return 1;
            2, 3:    return ALL_ONES - $urandom_range(0, 8);
            4, 5, 6: return $urandom_range(2, 255);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_zero_modulus();
        send_item('0, '0, '0);
        send_item(ALL_ONES, ALL_ONES, '0);
        send_item(32'h1234_5678, 32'h9abc_def0, '0);
    endtask

    task automatic test_zero_exponent();
        send_item(5, '0, 1);
        send_item(5, '0, 7);
        send_item('0, '0, ALL_ONES);
        send_item(ALL_ONES, '0, 2);
    endtask

    task automatic test_operand_extremes();
        send_item(ALL_ONES, ALL_ONES, ALL_ONES);
        send_item(ALL_ONES - 1, ALL_ONES, ALL_ONES);
        send_item(ALL_ONES, ALL_ONES, 1);
        send_item(ALL_ONES, 1, ALL_ONES - 1);
        send_item(2, 10, 1000);
        send_item('0, 5, 7);
        send_item(1, ALL_ONES, 7);
        send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0001);
        send_item(ALL_ONES, 2, 32'hffff_fffb);
        send_item(12345, 65537, 32'hffff_fffb);
        send_item(3, ALL_ONES, ALL_ONES - 4);
        send_item(ALL_ONES, ALL_ONES, 32'h8000_0000);
    endtask

    // Random mix; idling switches on and off between stretches.
    task automatic test_random_mix(input int count);
        logic [WIDTH-1:0] m;
        for (int i = 0; i < count; i++) begin
            if (idle_mix && i % 25 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            m = random_modulus();
            if (m != '0 && $urandom_range(0, 2) == 0)
                send_item($urandom % m, random_exponent(), m);
            else
                send_item($urandom, random_exponent(), m);
        end
    endtask

    // Let the block fully empty between short batches.
    task automatic test_drain_pause();
        idle_on = 1'b1;
        for (int i = 0; i < 4; i++) begin
            test_random_mix(5);
            wait_drained();
        end
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_no_idle();
        test_random_mix(1);
        idle_mix = 1'b0;
        idle_on  = 1'b0;
        test_random_mix(29);
    endtask

    // Receiver side: check each accepted result, then pick the next ready value.
    always @(posedge i_clk) begin : result_check
        power_exp_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_powers.size() == 0) begin
                $display("%0t: unexpected result power=%h zero_mod=%b",
                         $time, m_axis_tdata[WIDTH-1:0], m_axis_tuser);
                error_count++;
            end else begin
                want = expected_powers.pop_front();
                if (m_axis_tdata[WIDTH-1:0] !== want.power) begin
                    $display("%0t: power_result expected %h actual %h",
                             $time, want.power, m_axis_tdata[WIDTH-1:0]);
                    error_count++;
                end
                if (m_axis_tuser !== want.zero_mod) begin
                    $display("%0t: zero_modulus_error expected %b actual %b",
                             $time, want.zero_mod, m_axis_tuser);
                    error_count++;
                end
            end
        end
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 15) == 0) begin
            stall_left    <= $urandom_range(0, 18);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_modulus();
        test_zero_exponent();
        test_operand_extremes();
        test_random_mix(140);
        test_drain_pause();
        test_random_mix(80);
        test_no_idle();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
